[hdl/hdct_pkg.sv]
package hdct_pkg;

  localparam int unsigned VALUE_W = 64;
  localparam int unsigned QDEPTH  = 4;
  localparam int unsigned QAW     = $clog2(QDEPTH);
  localparam int unsigned QCW     = $clog2(QDEPTH + 1);

  localparam logic [7:0] CHAR_SPACE = 8'h20;
  localparam logic [7:0] CHAR_TAB   = 8'h09;
  localparam logic [7:0] CHAR_CR    = 8'h0D;
  localparam logic [7:0] CHAR_LF    = 8'h0A;
  localparam logic [7:0] CHAR_HASH  = 8'h23;
  localparam logic [7:0] CHAR_COLON = 8'h3A;
  localparam logic [7:0] CHAR_ZERO  = 8'h30;
  localparam logic [7:0] CHAR_ONE   = 8'h31;
  localparam logic [7:0] CHAR_NINE  = 8'h39;
  localparam logic [7:0] CHAR_LOW_X = 8'h78;
  localparam logic [7:0] CHAR_UP_X  = 8'h58;
  localparam logic [7:0] CHAR_LOW_A = 8'h61;
  localparam logic [7:0] CHAR_LOW_F = 8'h66;
  localparam logic [7:0] CHAR_UP_A  = 8'h41;
  localparam logic [7:0] CHAR_UP_F  = 8'h46;

  localparam logic [VALUE_W-1:0] DEC_LIMIT = 64'd1844674407370955161;
  localparam logic [3:0]         DEC_LAST  = 4'd5;

  typedef enum logic [2:0] {
    MODE_IDLE    = 3'd0,
    MODE_COMMENT = 3'd1,
    MODE_ZERO    = 3'd2,
    MODE_HEX     = 3'd3,
    MODE_DEC     = 3'd4
  } mode_t;

  typedef enum logic [2:0] {
    KIND_COLON = 3'd0,
    KIND_ADDR  = 3'd1,
    KIND_NUM   = 3'd2,
    KIND_END   = 3'd3,
    KIND_ERR   = 3'd4
  } kind_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       end_of_input;
  } byte_item_t;

  typedef struct packed {
    kind_t              token_kind;
    logic [VALUE_W-1:0] token_value;
    logic               overflowed;
    logic               last_of_run;
  } token_item_t;

  typedef struct packed {
    logic [1:0]  count;
    token_item_t first;
    token_item_t second;
  } step_out_t;

  function automatic logic [4:0] hex_digit(input logic [7:0] c);
    logic [4:0] r;
    r = 5'd0;
    if (c >= CHAR_ZERO && c <= CHAR_NINE) begin
      r = {1'b1, c[3:0]};
    end else if (c >= CHAR_LOW_A && c <= CHAR_LOW_F) begin
      r = {1'b1, 4'(c - CHAR_LOW_A + 8'd10)};
    end else if (c >= CHAR_UP_A && c <= CHAR_UP_F) begin
      r = {1'b1, 4'(c - CHAR_UP_A + 8'd10)};
    end
    return r;
  endfunction

endpackage

[hdl/hdct_step.sv]
module hdct_step (
  input  logic                clk,
  input  logic                rst,
  input  logic                accept,
  input  hdct_pkg::byte_item_t item,
  output hdct_pkg::step_out_t  res
);

  hdct_pkg::mode_t mode, mode_next;
  logic [hdct_pkg::VALUE_W-1:0] acc, acc_next;
  logic ovf, ovf_next;

  logic [7:0] c;
  logic       is_dec;
  logic [4:0] hd;

  hdct_pkg::mode_t st_mode;
  logic [hdct_pkg::VALUE_W-1:0] st_acc;
  logic            st_emit;
  hdct_pkg::kind_t st_kind;

  logic            flush_valid;
  hdct_pkg::kind_t flush_kind;
  logic [hdct_pkg::VALUE_W-1:0] flush_value;
  logic            flush_ovf;
  logic            tail_valid;
  hdct_pkg::kind_t tail_kind;

  hdct_pkg::token_item_t flush_tok, tail_tok;

  assign c      = item.data_byte;
  assign is_dec = (c >= hdct_pkg::CHAR_ZERO) && (c <= hdct_pkg::CHAR_NINE);
  assign hd     = hdct_pkg::hex_digit(c);

  always_comb begin
    st_mode = hdct_pkg::MODE_IDLE;
    st_acc  = '0;
    st_emit = 1'b0;
    st_kind = hdct_pkg::KIND_ERR;
    priority if (c == hdct_pkg::CHAR_SPACE || c == hdct_pkg::CHAR_TAB ||
                 c == hdct_pkg::CHAR_CR || c == hdct_pkg::CHAR_LF) begin
      st_mode = hdct_pkg::MODE_IDLE;
    end else if (c == hdct_pkg::CHAR_HASH) begin
      st_mode = hdct_pkg::MODE_COMMENT;
    end else if (c == hdct_pkg::CHAR_COLON) begin
      st_emit = 1'b1;
      st_kind = hdct_pkg::KIND_COLON;
    end else if (c == hdct_pkg::CHAR_ZERO) begin
      st_mode = hdct_pkg::MODE_ZERO;
    end else if (c >= hdct_pkg::CHAR_ONE && c <= hdct_pkg::CHAR_NINE) begin
      st_mode = hdct_pkg::MODE_DEC;
      st_acc  = hdct_pkg::VALUE_W'(c[3:0]);
    end else begin
      st_emit = 1'b1;
      st_kind = hdct_pkg::KIND_ERR;
    end
  end

  always_comb begin
    mode_next = mode;
    acc_next  = acc;
    ovf_next  = ovf;
    if (item.end_of_input) begin
      mode_next = hdct_pkg::MODE_IDLE;
      acc_next  = '0;
      ovf_next  = 1'b0;
    end else begin
      unique case (mode)
        hdct_pkg::MODE_COMMENT: begin
          if (c == hdct_pkg::CHAR_LF) begin
            mode_next = hdct_pkg::MODE_IDLE;
          end
        end
        hdct_pkg::MODE_ZERO: begin
          if (c == hdct_pkg::CHAR_LOW_X || c == hdct_pkg::CHAR_UP_X) begin
            mode_next = hdct_pkg::MODE_HEX;
            acc_next  = '0;
            ovf_next  = 1'b0;
          end else begin
            mode_next = st_mode;
            acc_next  = st_acc;
            ovf_next  = 1'b0;
          end
        end
        hdct_pkg::MODE_HEX: begin
          if (hd[4]) begin
            ovf_next = ovf | (acc[hdct_pkg::VALUE_W-1 -: 4] != 4'd0);
            acc_next = {acc[hdct_pkg::VALUE_W-5:0], hd[3:0]};
          end else begin
            mode_next = st_mode;
            acc_next  = st_acc;
            ovf_next  = 1'b0;
          end
        end
        hdct_pkg::MODE_DEC: begin
          if (is_dec) begin
            ovf_next = ovf | (acc > hdct_pkg::DEC_LIMIT) ||
                       (acc == hdct_pkg::DEC_LIMIT && c[3:0] > hdct_pkg::DEC_LAST);
            acc_next = {acc[hdct_pkg::VALUE_W-4:0], 3'b000} +
                       {acc[hdct_pkg::VALUE_W-2:0], 1'b0} +
                       hdct_pkg::VALUE_W'(c[3:0]);
          end else begin
            mode_next = st_mode;
            acc_next  = st_acc;
            ovf_next  = 1'b0;
          end
        end
        default: begin
          mode_next = st_mode;
          acc_next  = st_acc;
          ovf_next  = 1'b0;
        end
      endcase
    end
  end

  always_comb begin
    flush_valid = 1'b0;
    flush_kind  = hdct_pkg::KIND_NUM;
    flush_value = acc;
    flush_ovf   = ovf;
    tail_valid  = 1'b0;
    tail_kind   = st_kind;
    if (item.end_of_input) begin
      flush_valid = (mode == hdct_pkg::MODE_ZERO) || (mode == hdct_pkg::MODE_DEC) ||
                    (mode == hdct_pkg::MODE_HEX);
      flush_kind  = (mode == hdct_pkg::MODE_HEX) ? hdct_pkg::KIND_ADDR : hdct_pkg::KIND_NUM;
      tail_valid  = 1'b1;
      tail_kind   = hdct_pkg::KIND_END;
    end else begin
      unique case (mode)
        hdct_pkg::MODE_COMMENT: begin
          tail_valid = 1'b0;
        end
        hdct_pkg::MODE_ZERO: begin
          if (c != hdct_pkg::CHAR_LOW_X && c != hdct_pkg::CHAR_UP_X) begin
            flush_valid = 1'b1;
            flush_value = '0;
            flush_ovf   = 1'b0;
            tail_valid  = st_emit;
          end
        end
        hdct_pkg::MODE_HEX: begin
          if (!hd[4]) begin
            flush_valid = 1'b1;
            flush_kind  = hdct_pkg::KIND_ADDR;
            tail_valid  = st_emit;
          end
        end
        hdct_pkg::MODE_DEC: begin
          if (!is_dec) begin
            flush_valid = 1'b1;
            tail_valid  = st_emit;
          end
        end
        default: begin
          tail_valid = st_emit;
        end
      endcase
    end
  end

  always_comb begin
    flush_tok.token_kind  = flush_kind;
    flush_tok.token_value = flush_value;
    flush_tok.overflowed  = flush_ovf;
    flush_tok.last_of_run = !tail_valid;
    tail_tok.token_kind   = tail_kind;
    tail_tok.token_value  = '0;
    tail_tok.overflowed   = 1'b0;
    tail_tok.last_of_run  = 1'b1;
    res.count  = 2'd0;
    res.first  = tail_tok;
    res.second = tail_tok;
    if (accept) begin
      if (flush_valid) begin
        res.first = flush_tok;
        res.count = tail_valid ? 2'd2 : 2'd1;
      end else if (tail_valid) begin
        res.count = 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= hdct_pkg::MODE_IDLE;
      acc  <= '0;
      ovf  <= 1'b0;
    end else if (accept) begin
      mode <= mode_next;
      acc  <= acc_next;
      ovf  <= ovf_next;
    end
  end

`ifndef ASSERT_OFF
  a_end_clears: assert property (@(posedge clk) disable iff (rst)
    (accept && item.end_of_input) |=> (mode == hdct_pkg::MODE_IDLE && acc == '0 && !ovf))
    else $error("end of input did not clear scan state");
  a_idle_acc_zero: assert property (@(posedge clk) disable iff (rst)
    (mode == hdct_pkg::MODE_IDLE || mode == hdct_pkg::MODE_COMMENT) |-> (acc == '0 && !ovf))
    else $error("value held outside a number");
  a_pair_order: assert property (@(posedge clk) disable iff (rst)
    (res.count == 2'd2) |-> (!res.first.last_of_run &&
                             (res.first.token_kind == hdct_pkg::KIND_NUM ||
                              res.first.token_kind == hdct_pkg::KIND_ADDR)))
    else $error("two results without a leading number");
`endif

endmodule

[hdl/hdct_queue.sv]
module hdct_queue (
  input  logic                  clk,
  input  logic                  rst,
  input  hdct_pkg::step_out_t    push,
  output logic                  full,
  output logic                  valid,
  input  logic                  stall,
  output hdct_pkg::token_item_t data
);

  hdct_pkg::token_item_t mem [hdct_pkg::QDEPTH];
  logic [hdct_pkg::QAW-1:0] wr_ptr, rd_ptr;
  logic [hdct_pkg::QCW-1:0] count;
  logic pop;

  assign valid = (count != '0);
  assign pop   = valid && !stall;
  assign full  = (count > hdct_pkg::QCW'(hdct_pkg::QDEPTH - 2));
  assign data  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push.count != 2'd0) begin
      mem[wr_ptr] <= push.first;
    end
    if (push.count == 2'd2) begin
      mem[wr_ptr + hdct_pkg::QAW'(1)] <= push.second;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + hdct_pkg::QAW'(push.count);
      if (pop) begin
        rd_ptr <= rd_ptr + hdct_pkg::QAW'(1);
      end
      count <= count + hdct_pkg::QCW'(push.count) - hdct_pkg::QCW'(pop);
    end
  end

`ifndef ASSERT_OFF
  a_no_overrun: assert property (@(posedge clk) disable iff (rst)
    (push.count != 2'd0) |-> (count <= hdct_pkg::QCW'(hdct_pkg::QDEPTH) -
                               hdct_pkg::QCW'(push.count)))
    else $error("token queue overrun");
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= hdct_pkg::QCW'(hdct_pkg::QDEPTH))
    else $error("token queue count out of range");
  a_drain: assert property (@(posedge clk) disable iff (rst)
    (pop && push.count == 2'd0) |=> (count == $past(count) - hdct_pkg::QCW'(1)))
    else $error("token queue lost track of a transfer");
`endif

endmodule

[hdl/hex_decimal_colon_tokenizer.sv]
// channel  | valid        | stall        | payload
// ---------+--------------+--------------+------------------------------
// bytes    | byte_valid   | byte_stall   | byte_item  (data_byte, end_of_input)
// tokens   | token_valid  | token_stall  | token_item (kind, value, overflowed, last)
//
// One byte per cycle while byte_stall is low; the scan state updates in the cycle of the transfer.
// A token is registered into a 4-entry queue and offered from there.
// A byte that gives two tokens pushes both into the queue at once; they leave it one after the other.
// byte_stall rises while the queue has fewer than two free entries.
// rst is synchronous: idle scan mode, value and overflow cleared, queue empty.
module hex_decimal_colon_tokenizer (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  byte_valid,
  output logic                  byte_stall,
  input  hdct_pkg::byte_item_t   byte_item,
  output logic                  token_valid,
  input  logic                  token_stall,
  output hdct_pkg::token_item_t token_item
);

  hdct_pkg::step_out_t res;
  logic accept;

  assign accept = byte_valid && !byte_stall;

  hdct_step u_step (
    .clk    (clk),
    .rst    (rst),
    .accept (accept),
    .item   (byte_item),
    .res    (res)
  );

  hdct_queue u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (res),
    .full  (byte_stall),
    .valid (token_valid),
    .stall (token_stall),
    .data  (token_item)
  );

endmodule
